### src/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg: shared types and constants for the k-nearest-neighbor selector
// Default sizes, the fixed distance width and the control struct that the
// top level broadcasts to every cell of the sorted chain.
// ----------------------------------------------------------------------------
`default_nettype none

package knn_pkg;

    // Default sizes for the top-level parameters.
    localparam int NEIGHBORS_DEF  = 5;
    localparam int ID_BITS_DEF    = 16;
    localparam int COORD_BITS_DEF = 16;

    // The squared distance is always carried at this width, saturating.
    localparam int DIST_BITS = 32;

    // Per-item flags that travel with a point through the distance pipeline.
    typedef struct packed {
        logic first;
        logic last;
    } item_flags_t;

    // Command broadcast to every cell of the chain in the same cycle.
    typedef struct packed {
        logic insert;   // place the incoming entry into the sorted list
        logic clear;    // treat the list as empty before this insertion
        logic rotate;   // shift held entries one cell toward the head
    } cell_ctrl_t;

endpackage : knn_pkg

`default_nettype wire

### src/knn_dist.sv
// ----------------------------------------------------------------------------
// knn_dist: two-stage squared-distance pipeline
// Stage one forms the absolute coordinate difference, stage two squares it
// and saturates the result to the distance width.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_dist
    import knn_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [COORD_BITS-1:0] query_point,
    input  logic signed [COORD_BITS-1:0] source_point,
    input  logic        [ID_BITS-1:0]    source_id,
    input  item_flags_t                  in_flags,
    output logic                         out_valid,
    output logic        [DIST_BITS-1:0]  out_dist,
    output logic        [ID_BITS-1:0]    out_id,
    output item_flags_t                  out_flags
);

    localparam int MAG_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * MAG_BITS;

    logic signed [MAG_BITS-1:0]     diff;
    logic        [MAG_BITS-1:0]     mag_next;
    logic        [MAG_BITS-1:0]     mag_reg;
    logic        [ID_BITS-1:0]      id1_reg;
    item_flags_t                    flags1_reg;
    logic                           valid1_reg;
    logic        [PROD_BITS-1:0]    prod;
    logic        [PROD_BITS+31:0]   prod_wide;
    logic        [DIST_BITS-1:0]    dist_next;
    logic        [DIST_BITS-1:0]    dist_reg;
    logic        [ID_BITS-1:0]      id2_reg;
    item_flags_t                    flags2_reg;
    logic                           valid2_reg;

    // Difference one bit wider than the coordinates, then its magnitude.
    assign diff     = MAG_BITS'(query_point) - MAG_BITS'(source_point);
    assign mag_next = diff[MAG_BITS-1] ? MAG_BITS'(-diff) : MAG_BITS'(diff);

    // Square the magnitude; any bit above the distance width saturates.
    assign prod      = PROD_BITS'(mag_reg) * PROD_BITS'(mag_reg);
    assign prod_wide = {32'b0, prod};
    assign dist_next = (|prod_wide[PROD_BITS+31:DIST_BITS]) ? '1
                                                             : prod_wide[DIST_BITS-1:0];

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    // Payload of both stages.
    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        id1_reg    <= source_id;
        flags1_reg <= in_flags;
        dist_reg   <= dist_next;
        id2_reg    <= id1_reg;
        flags2_reg <= flags1_reg;
    end

    assign out_valid = valid2_reg;
    assign out_dist  = dist_reg;
    assign out_id    = id2_reg;
    assign out_flags = flags2_reg;

endmodule : knn_dist

`default_nettype wire

### src/knn_cell.sv
// ----------------------------------------------------------------------------
// knn_cell: one entry of the sorted neighbor chain
// Holds a distance and an index. On insertion it takes its left neighbor's
// entry, the new entry or keeps its own; on rotation it takes the entry of
// its right neighbor, or the head's entry when it is the last held cell.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_cell
    import knn_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
)
(
    input  logic                 clk,
    input  cell_ctrl_t           ctrl,
    input  logic [DIST_BITS-1:0] new_dist,
    input  logic [ID_BITS-1:0]   new_id,
    input  logic                 occ,
    input  logic                 occ_eff,
    input  logic                 left_occ_eff,
    input  logic                 left_lt,
    input  logic [DIST_BITS-1:0] left_dist,
    input  logic [ID_BITS-1:0]   left_id,
    input  logic                 right_occ,
    input  logic [DIST_BITS-1:0] right_dist,
    input  logic [ID_BITS-1:0]   right_id,
    input  logic [DIST_BITS-1:0] head_dist,
    input  logic [ID_BITS-1:0]   head_id,
    output logic [DIST_BITS-1:0] held_dist,
    output logic [ID_BITS-1:0]   id,
    output logic                 lt
);

    logic [DIST_BITS-1:0] dist_reg;
    logic [DIST_BITS-1:0] dist_next;
    logic [ID_BITS-1:0]   id_reg;
    logic [ID_BITS-1:0]   id_next;
    logic                 take_new;

    // The new entry is strictly closer than this held entry.
    assign lt = occ_eff && (new_dist < dist_reg);

    // The new entry lands here when the left cell keeps its entry and this
    // cell is either free or holds a farther one.
    assign take_new = left_occ_eff && !left_lt && (!occ_eff || lt);

    // Next entry of the cell.
    always_comb
    begin
        dist_next = dist_reg;
        id_next   = id_reg;
        if (ctrl.insert)
        begin
            if (left_lt)
            begin
                dist_next = left_dist;
                id_next   = left_id;
            end
            else if (take_new)
            begin
                dist_next = new_dist;
                id_next   = new_id;
            end
        end
        else if (ctrl.rotate && occ)
        begin
            dist_next = right_occ ? right_dist : head_dist;
            id_next   = right_occ ? right_id   : head_id;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        id_reg   <= id_next;
    end

    assign held_dist = dist_reg;
    assign id        = id_reg;

endmodule : knn_cell

`default_nettype wire

### src/k_nearest_neighbor_selector_unit.sv
// ----------------------------------------------------------------------------
// k_nearest_neighbor_selector_unit: brute-force K-nearest-neighbor selector
// Streams source points, keeps the NEIGHBORS closest in a sorted cell chain
// and emits them nearest first when a query closes.
// ----------------------------------------------------------------------------
// A point beat is taken every cycle while a query is open; its squared
// distance passes the magnitude and distance registers of the pipeline and
// is placed into a chain of NEIGHBORS cells, every cell comparing against
// the new distance at once. A beat with tlast set closes the query: the
// input then stalls while that beat crosses the distance pipeline and for
// one output beat per held neighbor (1 to NEIGHBORS), during which the
// chain rotates one cell per accepted output beat and ends in its original
// order. The list survives emission, so points may keep accumulating into
// it when the next beat has tuser low.
`default_nettype none

module k_nearest_neighbor_selector_unit
    import knn_pkg::*;
#(
    parameter int NEIGHBORS  = NEIGHBORS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int S_TDATA_W = 8 * ((2 * COORD_BITS + ID_BITS + 7) / 8),
    localparam int RANK_BITS = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1,
    localparam int M_TDATA_W = 8 * ((RANK_BITS + DIST_BITS + ID_BITS + 7) / 8)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Point beats.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // query_point, source_point, source_id
    input  logic                 s_tuser,   // first_of_query
    input  logic                 s_tlast,   // last_of_query
    // Neighbor beats.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // rank, distance_squared, neighbor_id
    output logic                 m_tlast    // last_of_run
);

    localparam int CNT_BITS = $clog2(NEIGHBORS + 1);

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;
    logic [RANK_BITS-1:0] rank_reg;
    logic [RANK_BITS-1:0] rank_next;

    logic                 in_fire;
    logic                 out_fire;
    logic                 final_beat;
    item_flags_t          in_flags;
    logic                 ins_valid;
    logic [DIST_BITS-1:0] ins_dist;
    logic [ID_BITS-1:0]   ins_id;
    item_flags_t          ins_flags;
    cell_ctrl_t           ctrl;

    logic [DIST_BITS-1:0] cell_dist [NEIGHBORS];
    logic [ID_BITS-1:0]   cell_id   [NEIGHBORS];
    logic [NEIGHBORS-1:0] cell_lt;
    logic [NEIGHBORS-1:0] occ;
    logic [NEIGHBORS-1:0] occ_eff;

    // Handshakes.
    assign s_tready = (state_reg == ST_RUN);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign in_flags = '{first: s_tuser, last: s_tlast};

    // Squared-distance pipeline.
    knn_dist #(
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS)
    ) u_dist (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_fire),
        .query_point  (s_tdata[COORD_BITS-1:0]),
        .source_point (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .source_id    (s_tdata[2*COORD_BITS+ID_BITS-1:2*COORD_BITS]),
        .in_flags     (in_flags),
        .out_valid    (ins_valid),
        .out_dist     (ins_dist),
        .out_id       (ins_id),
        .out_flags    (ins_flags)
    );

    // Command to the chain.
    assign ctrl = '{insert: ins_valid,
                    clear:  ins_valid && ins_flags.first,
                    rotate: out_fire};

    // Cell chain: occupancy follows the held count.
    genvar gi;
    generate
        for (gi = 0; gi < NEIGHBORS; gi++)
        begin : g_cell
            logic                 l_occ_eff;
            logic                 l_lt;
            logic [DIST_BITS-1:0] l_dist;
            logic [ID_BITS-1:0]   l_id;
            logic                 r_occ;
            logic [DIST_BITS-1:0] r_dist;
            logic [ID_BITS-1:0]   r_id;

            assign occ[gi]     = (CNT_BITS'(gi) < count_reg);
            assign occ_eff[gi] = occ[gi] && !ctrl.clear;

            if (gi == 0)
            begin : g_head
                assign l_occ_eff = 1'b1;
                assign l_lt      = 1'b0;
                assign l_dist    = '0;
                assign l_id      = '0;
            end
            else
            begin : g_body
                assign l_occ_eff = occ_eff[gi-1];
                assign l_lt      = cell_lt[gi-1];
                assign l_dist    = cell_dist[gi-1];
                assign l_id      = cell_id[gi-1];
            end

            if (gi == NEIGHBORS - 1)
            begin : g_tail
                assign r_occ  = 1'b0;
                assign r_dist = '0;
                assign r_id   = '0;
            end
            else
            begin : g_inner
                assign r_occ  = occ[gi+1];
                assign r_dist = cell_dist[gi+1];
                assign r_id   = cell_id[gi+1];
            end

            knn_cell #(
                .ID_BITS (ID_BITS)
            ) u_cell (
                .clk          (clk),
                .ctrl         (ctrl),
                .new_dist     (ins_dist),
                .new_id       (ins_id),
                .occ          (occ[gi]),
                .occ_eff      (occ_eff[gi]),
                .left_occ_eff (l_occ_eff),
                .left_lt      (l_lt),
                .left_dist    (l_dist),
                .left_id      (l_id),
                .right_occ    (r_occ),
                .right_dist   (r_dist),
                .right_id     (r_id),
                .head_dist    (cell_dist[0]),
                .head_id      (cell_id[0]),
                .held_dist    (cell_dist[gi]),
                .id           (cell_id[gi]),
                .lt           (cell_lt[gi])
            );
        end
    endgenerate

    // Held count: a clear leaves only the new entry, a full list stays full.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert)
        begin
            if (ctrl.clear)
            begin
                count_next = CNT_BITS'(1);
            end
            else if (count_reg != CNT_BITS'(NEIGHBORS))
            begin
                count_next = count_reg + CNT_BITS'(1);
            end
        end
    end

    // The final beat of a run is the one whose rank is the last held entry.
    assign final_beat = ((CNT_BITS'(rank_reg) + CNT_BITS'(1)) == count_reg);

    // Control sequence: accept points, wait for the closing point, drain.
    always_comb
    begin
        state_next = state_reg;
        rank_next  = rank_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (in_fire && s_tlast)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (ins_valid && ins_flags.last)
                begin
                    state_next = ST_DRAIN;
                    rank_next  = '0;
                end
            end
            ST_DRAIN:
            begin
                if (out_fire)
                begin
                    rank_next = rank_reg + RANK_BITS'(1);
                    if (final_beat)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            count_reg <= '0;
            rank_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    // Output beat straight from the head cell and the rank register.
    assign m_tvalid = (state_reg == ST_DRAIN);
    assign m_tdata  = M_TDATA_W'({cell_id[0], cell_dist[0], rank_reg});
    assign m_tlast  = final_beat;

endmodule : k_nearest_neighbor_selector_unit

`default_nettype wire
